// ===== src/btpd_pkg.sv =====
package btpd_pkg;

  // Default width of the saturating integral sums
  localparam int ACC_BITS_DEF = 32;

  // Fixed-point and drive constants
  localparam int DRIVE_LIMIT = 125;
  localparam int ONE_Q16     = 65536;
  localparam int HALF_Q16    = 32768;
  localparam int Q12_SHIFT   = 12;
  localparam int Q16_SHIFT   = 16;

  // Register reset values
  localparam logic [9:0]  TARGET_DISTANCE_RST = 10'd180;
  localparam logic [15:0] ANGLE_P_GAIN_RST    = 16'd410;
  localparam logic [15:0] ANGLE_D_GAIN_RST    = 16'd819;
  localparam logic [15:0] ANGLE_I_GAIN_RST    = 16'd0;
  localparam logic [15:0] DIST_P_GAIN_RST     = 16'd2458;
  localparam logic [15:0] DIST_D_GAIN_RST     = 16'd2048;
  localparam logic [15:0] DIST_I_GAIN_RST     = 16'd41;
  localparam logic [15:0] SMOOTHING_RST       = 16'd6554;

  // Register indexes (byte address is four times the index)
  localparam logic [2:0] REG_TARGET_DISTANCE = 3'd0;
  localparam logic [2:0] REG_ANGLE_P_GAIN    = 3'd1;
  localparam logic [2:0] REG_ANGLE_D_GAIN    = 3'd2;
  localparam logic [2:0] REG_ANGLE_I_GAIN    = 3'd3;
  localparam logic [2:0] REG_DIST_P_GAIN     = 3'd4;
  localparam logic [2:0] REG_DIST_D_GAIN     = 3'd5;
  localparam logic [2:0] REG_DIST_I_GAIN     = 3'd6;
  localparam logic [2:0] REG_SMOOTHING       = 3'd7;

  // Input word kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

endpackage

// ===== src/ball_tracking_pid_drive.sv =====
// Dual PID differential drive. Each tracking sample (tuser = 0) updates the angle and distance
// loops and yields one word of wheel commands; a clear word (tuser = 1) zeroes both integral
// sums and yields nothing. A tracking sample occupies the block from its acceptance to the next
// possible acceptance: acceptance registers the errors and sums of the word, then
// a sequencer runs twelve products through a single shared 18 x 33 bit signed multiplier
// (P, D and the two halves of I for each loop, then two blend products per running average),
// followed by the average updates and the output register. s_tready stays low during that
// time; a finished result waits in the output register, and the sequencer holds its final
// step if the previous result has not yet been taken.
module ball_tracking_pid_drive #(
  parameter int ACC_BITS = btpd_pkg::ACC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [10:0] ball_offset, [20:11] ball_radius, [23:21] zero
  input  logic        s_tuser,   // [0] kind
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [7:0] left_drive, [15:8] right_drive
);
  import btpd_pkg::*;

  localparam int LO_W   = ACC_BITS / 2;
  localparam int HI_W   = ACC_BITS - LO_W;
  localparam int OPA_W  = 18;
  localparam int OPB_W  = 33;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = (ACC_BITS + 18 > PROD_W) ? ACC_BITS + 18 : PROD_W;
  localparam int STEP_W = 4;

  // Sequencer steps
  localparam logic [STEP_W-1:0] ST_MUL_AP   = 4'd0;
  localparam logic [STEP_W-1:0] ST_MUL_AD   = 4'd1;
  localparam logic [STEP_W-1:0] ST_MUL_AIL  = 4'd2;
  localparam logic [STEP_W-1:0] ST_MUL_AIH  = 4'd3;
  localparam logic [STEP_W-1:0] ST_MUL_DP   = 4'd4;
  localparam logic [STEP_W-1:0] ST_MUL_DD   = 4'd5;
  localparam logic [STEP_W-1:0] ST_MUL_DIL  = 4'd6;
  localparam logic [STEP_W-1:0] ST_MUL_DIH  = 4'd7;
  localparam logic [STEP_W-1:0] ST_MUL_AOLD = 4'd8;
  localparam logic [STEP_W-1:0] ST_MUL_ANEW = 4'd9;
  localparam logic [STEP_W-1:0] ST_MUL_DOLD = 4'd10;
  localparam logic [STEP_W-1:0] ST_MUL_DNEW = 4'd11;
  localparam logic [STEP_W-1:0] ST_ADD_DNEW = 4'd12;
  localparam logic [STEP_W-1:0] ST_DIST_AVG = 4'd13;
  localparam logic [STEP_W-1:0] ST_OUT      = 4'd14;

  localparam logic signed [ACC_W-1:0] MAX32 = ACC_W'(33'sh0_7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] MIN32 = ACC_W'(33'sh1_8000_0000);
  localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(HALF_Q16);

  // Configuration registers
  logic        [9:0]  target_distance;
  logic signed [15:0] angle_p_gain, angle_d_gain, angle_i_gain;
  logic signed [15:0] dist_p_gain, dist_d_gain, dist_i_gain;
  logic        [15:0] smoothing;

  // Loop state
  logic signed [11:0]         prev_angle_err, prev_dist_err;
  logic signed [ACC_BITS-1:0] angle_err_sum, dist_err_sum;
  logic signed [31:0]         angle_avg, dist_avg;

  // Per-sample working registers
  logic signed [11:0]      angle_err, dist_err;
  logic signed [12:0]      angle_diff, dist_diff;
  logic signed [31:0]      angle_pid, dist_pid;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                    busy;
  logic [STEP_W-1:0]       step;

  logic signed [11:0]         in_angle_err, in_dist_err;
  logic signed [ACC_BITS-1:0] angle_sum_next, dist_sum_next;
  logic signed [OPA_W-1:0]    op_a;
  logic signed [OPB_W-1:0]    op_b;
  logic signed [PROD_W-1:0]   mul_res;
  logic signed [ACC_W-1:0]    prod_ext, prod_sh, blend_sh;
  logic signed [31:0]         acc_sat, blend_sat;
  logic [16:0]                one_minus_a;
  logic signed [HI_W-1:0]     angle_hi, dist_hi;
  logic [LO_W-1:0]            angle_lo, dist_lo;
  logic signed [7:0]          left_next, right_next;
  logic                       cfg_wr, s_acc, out_free;

  function automatic logic signed [ACC_BITS-1:0] sum_add(
    input logic signed [ACC_BITS-1:0] s,
    input logic signed [11:0]         e
  );
    logic signed [ACC_BITS:0] t;
    t = (ACC_BITS+1)'(s) + (ACC_BITS+1)'(e);
    if (t[ACC_BITS] != t[ACC_BITS-1]) begin
      sum_add = {t[ACC_BITS], {(ACC_BITS-1){~t[ACC_BITS]}}};
    end else begin
      sum_add = t[ACC_BITS-1:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > MAX32) begin
      sat32 = MAX32[31:0];
    end else if (v < MIN32) begin
      sat32 = MIN32[31:0];
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // Truncate a Q.12 value toward zero, then clamp to the drive range
  function automatic logic signed [7:0] drive(input logic signed [32:0] x);
    logic signed [32:0] q;
    q = (x + (x[32] ? 33'sd4095 : 33'sd0)) >>> Q12_SHIFT;
    if (q > 33'(DRIVE_LIMIT)) begin
      drive = 8'(DRIVE_LIMIT);
    end else if (q < -33'(DRIVE_LIMIT)) begin
      drive = -8'(DRIVE_LIMIT);
    end else begin
      drive = q[7:0];
    end
  endfunction

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign s_tready = !busy;
  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Register readback
  always_comb begin
    unique case (paddr[4:2])
      REG_TARGET_DISTANCE: prdata = {22'd0, target_distance};
      REG_ANGLE_P_GAIN:    prdata = {16'd0, angle_p_gain};
      REG_ANGLE_D_GAIN:    prdata = {16'd0, angle_d_gain};
      REG_ANGLE_I_GAIN:    prdata = {16'd0, angle_i_gain};
      REG_DIST_P_GAIN:     prdata = {16'd0, dist_p_gain};
      REG_DIST_D_GAIN:     prdata = {16'd0, dist_d_gain};
      REG_DIST_I_GAIN:     prdata = {16'd0, dist_i_gain};
      REG_SMOOTHING:       prdata = {16'd0, smoothing};
      default:             prdata = 32'd0;
    endcase
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_distance <= TARGET_DISTANCE_RST;
      angle_p_gain    <= ANGLE_P_GAIN_RST;
      angle_d_gain    <= ANGLE_D_GAIN_RST;
      angle_i_gain    <= ANGLE_I_GAIN_RST;
      dist_p_gain     <= DIST_P_GAIN_RST;
      dist_d_gain     <= DIST_D_GAIN_RST;
      dist_i_gain     <= DIST_I_GAIN_RST;
      smoothing       <= SMOOTHING_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_TARGET_DISTANCE: target_distance <= pwdata[9:0];
        REG_ANGLE_P_GAIN:    angle_p_gain    <= pwdata[15:0];
        REG_ANGLE_D_GAIN:    angle_d_gain    <= pwdata[15:0];
        REG_ANGLE_I_GAIN:    angle_i_gain    <= pwdata[15:0];
        REG_DIST_P_GAIN:     dist_p_gain     <= pwdata[15:0];
        REG_DIST_D_GAIN:     dist_d_gain     <= pwdata[15:0];
        REG_DIST_I_GAIN:     dist_i_gain     <= pwdata[15:0];
        REG_SMOOTHING:       smoothing       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Errors and saturated sums of the incoming word
  assign in_angle_err   = 12'(signed'(s_tdata[10:0]));
  assign in_dist_err    = signed'({2'b00, target_distance}) - signed'({2'b00, s_tdata[20:11]});
  assign angle_sum_next = sum_add(angle_err_sum, in_angle_err);
  assign dist_sum_next  = sum_add(dist_err_sum, in_dist_err);

  // Split the sums so each half fits the multiplier
  assign angle_lo    = angle_err_sum[LO_W-1:0];
  assign angle_hi    = angle_err_sum[ACC_BITS-1:LO_W];
  assign dist_lo     = dist_err_sum[LO_W-1:0];
  assign dist_hi     = dist_err_sum[ACC_BITS-1:LO_W];
  assign one_minus_a = 17'(ONE_Q16) - {1'b0, smoothing};

  // Select multiplier operands for the current step
  always_comb begin
    unique case (step)
      ST_MUL_AP: begin
        op_a = OPA_W'(angle_p_gain);
        op_b = OPB_W'(angle_err);
      end
      ST_MUL_AD: begin
        op_a = OPA_W'(angle_d_gain);
        op_b = OPB_W'(angle_diff);
      end
      ST_MUL_AIL: begin
        op_a = OPA_W'(angle_i_gain);
        op_b = OPB_W'(signed'({1'b0, angle_lo}));
      end
      ST_MUL_AIH: begin
        op_a = OPA_W'(angle_i_gain);
        op_b = OPB_W'(angle_hi);
      end
      ST_MUL_DP: begin
        op_a = OPA_W'(dist_p_gain);
        op_b = OPB_W'(dist_err);
      end
      ST_MUL_DD: begin
        op_a = OPA_W'(dist_d_gain);
        op_b = OPB_W'(dist_diff);
      end
      ST_MUL_DIL: begin
        op_a = OPA_W'(dist_i_gain);
        op_b = OPB_W'(signed'({1'b0, dist_lo}));
      end
      ST_MUL_DIH: begin
        op_a = OPA_W'(dist_i_gain);
        op_b = OPB_W'(dist_hi);
      end
      ST_MUL_AOLD: begin
        op_a = signed'({1'b0, one_minus_a});
        op_b = OPB_W'(angle_avg);
      end
      ST_MUL_ANEW: begin
        op_a = signed'({2'b00, smoothing});
        op_b = OPB_W'(angle_pid);
      end
      ST_MUL_DOLD: begin
        op_a = signed'({1'b0, one_minus_a});
        op_b = OPB_W'(dist_avg);
      end
      ST_MUL_DNEW: begin
        op_a = signed'({2'b00, smoothing});
        op_b = OPB_W'(dist_pid);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_res    = op_a * op_b;
  assign prod_ext   = ACC_W'(prod);
  assign prod_sh    = prod_ext <<< LO_W;
  assign acc_sat    = sat32(acc);
  assign blend_sh   = acc >>> Q16_SHIFT;
  assign blend_sat  = sat32(blend_sh);
  assign left_next  = drive(33'(dist_avg) + 33'(angle_avg));
  assign right_next = drive(33'(dist_avg) - 33'(angle_avg));

  // Shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod <= mul_res;
  end

  // Accumulate products and capture loop results
  always_ff @(posedge clk) begin
    if (busy) begin
      unique case (step)
        ST_MUL_AD, ST_MUL_DD: acc <= prod_ext;
        ST_MUL_AIL, ST_MUL_AIH, ST_MUL_DIL, ST_MUL_DIH, ST_ADD_DNEW: begin
          acc <= acc + prod_ext;
        end
        ST_MUL_DP: begin
          acc <= acc + prod_sh;
        end
        ST_MUL_AOLD: begin
          acc <= acc + prod_sh;
        end
        // Start a running average blend with the rounding half
        ST_MUL_ANEW, ST_MUL_DNEW: begin
          acc <= prod_ext + HALF;
        end
        ST_MUL_DOLD: begin
          acc <= acc + prod_ext;
        end
        default: ;
      endcase
      // Capture apid once its sum is complete at DD, dpid at ANEW
      if (step == ST_MUL_DD) begin
        angle_pid <= acc_sat;
      end
      if (step == ST_MUL_ANEW) begin
        dist_pid <= acc_sat;
      end
    end
  end

  // Sequencer, loop state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      step           <= ST_MUL_AP;
      m_tvalid       <= 1'b0;
      prev_angle_err <= '0;
      prev_dist_err  <= '0;
      angle_err_sum  <= '0;
      dist_err_sum   <= '0;
      angle_avg      <= '0;
      dist_avg       <= '0;
    end else begin
      if (m_tvalid && m_tready && !(busy && step == ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      if (s_acc) begin
        if (s_tuser == KIND_CLEAR) begin
          angle_err_sum <= '0;
          dist_err_sum  <= '0;
        end else begin
          angle_err_sum  <= angle_sum_next;
          dist_err_sum   <= dist_sum_next;
          prev_angle_err <= in_angle_err;
          prev_dist_err  <= in_dist_err;
          busy           <= 1'b1;
          step           <= ST_MUL_AP;
        end
      end else if (busy) begin
        priority if (step == ST_OUT) begin
          // Hold here until the output register is free
          if (out_free) begin
            m_tvalid <= 1'b1;
            busy     <= 1'b0;
            step     <= ST_MUL_AP;
          end
        end else begin
          step <= step + 1'b1;
        end
        // The angle blend is complete in acc while the DNEW product is formed
        if (step == ST_MUL_DNEW) begin
          angle_avg <= blend_sat;
        end
        if (step == ST_DIST_AVG) begin
          dist_avg <= blend_sat;
        end
      end
    end
  end

  // Working copies of errors and differences for the sequencer
  always_ff @(posedge clk) begin
    if (s_acc && s_tuser == KIND_SAMPLE) begin
      angle_err  <= in_angle_err;
      dist_err   <= in_dist_err;
      angle_diff <= 13'(in_angle_err) - 13'(prev_angle_err);
      dist_diff  <= 13'(in_dist_err) - 13'(prev_dist_err);
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (busy && step == ST_OUT && out_free) begin
      m_tdata <= {right_next, left_next};
    end
  end

  // A tracking sample starts the sequencer at its first step
  a_start: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == KIND_SAMPLE |=> busy && step == ST_MUL_AP)
    else $error("sequencer did not start on a tracking sample");

  // The step counter never runs past the output step
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> step <= ST_OUT)
    else $error("sequencer step out of range");

  // A new result only appears from the output step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(busy && step == ST_OUT))
    else $error("result word raised outside the output step");

  // A clear word zeroes both integral sums
  a_clear: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == KIND_CLEAR |=> angle_err_sum == '0 && dist_err_sum == '0)
    else $error("integral sums not cleared");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import btpd_pkg::*;

  localparam int     LIMIT_CYCLES = 400000;
  localparam int     SETTLE_CYCLES = 40;
  localparam longint SUM_HI = (64'sd1 <<< (ACC_BITS_DEF - 1)) - 64'sd1;
  localparam longint SUM_LO = -SUM_HI - 64'sd1;
  localparam longint AVG_HI = 64'sd2147483647;
  localparam longint AVG_LO = -AVG_HI - 64'sd1;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // [10:0] ball_offset, [20:11] ball_radius, [23:21] zero
  logic        s_tuser;   // [0] kind
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [7:0] left_drive, [15:8] right_drive

  ball_tracking_pid_drive u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Register mirror
  longint tgt_dist, a_kp, a_kd, a_ki, d_kp, d_kd, d_ki, avg_alpha;
  // Loop state mirror
  longint prev_a_err, prev_d_err, a_err_sum, d_err_sum, a_avg, d_avg;

  logic [15:0] drive_cmd_q [$];
  logic [15:0] want_word;
  int          err_cnt;
  int          cycle_cnt;
  int          send_idle_pct;
  int          recv_idle_pct;

  // Directed words: typed flag marks rows whose wheel commands are obvious
  typedef struct packed {
    logic        kind;
    logic [10:0] off;
    logic [9:0]  rad;
    logic        typed;
    logic [15:0] word;
  } dir_row_t;

  localparam int DIR_ROWS = 21;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{KIND_SAMPLE, 11'd0,   10'd180,  1'b1, 16'h0000},  // on target from reset
    '{KIND_SAMPLE, 11'd0,   10'd180,  1'b1, 16'h0000},
    '{KIND_CLEAR,  11'd0,   10'd0,    1'b0, 16'h0000},
    '{KIND_SAMPLE, 11'h3FF, 10'd180,  1'b0, 16'h0000},
    '{KIND_SAMPLE, 11'h400, 10'd180,  1'b0, 16'h0000},
    '{KIND_SAMPLE, 11'd0,   10'd0,    1'b0, 16'h0000},
    '{KIND_SAMPLE, 11'd0,   10'h3FF,  1'b0, 16'h0000},
    '{KIND_SAMPLE, 11'h3FF, 10'd0,    1'b0, 16'h0000},
    '{KIND_SAMPLE, 11'h400, 10'h3FF,  1'b0, 16'h0000},
    '{KIND_CLEAR,  11'h7FF, 10'h3FF,  1'b0, 16'h0000},
    '{KIND_SAMPLE, 11'h555, 10'h2AA,  1'b0, 16'h0000},
    '{KIND_SAMPLE, 11'h2AA, 10'h155,  1'b0, 16'h0000},
    '{KIND_SAMPLE, 11'h3FF, 10'd0,    1'b0, 16'h0000},
    '{KIND_SAMPLE, 11'h3FF, 10'd0,    1'b0, 16'h0000},
    '{KIND_SAMPLE, 11'h3FF, 10'd0,    1'b0, 16'h0000},
    '{KIND_SAMPLE, 11'h3FF, 10'd0,    1'b0, 16'h0000},
    '{KIND_SAMPLE, 11'h3FF, 10'd0,    1'b0, 16'h0000},
    '{KIND_SAMPLE, 11'h3FF, 10'd0,    1'b0, 16'h0000},
    '{KIND_CLEAR,  11'h3FF, 10'd0,    1'b0, 16'h0000},
    '{KIND_SAMPLE, 11'h7FF, 10'd1,    1'b0, 16'h0000},
    '{KIND_SAMPLE, 11'd1,   10'h3FE,  1'b0, 16'h0000}
  };

  function automatic longint clip(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // Running average update, rounded to nearest with halves up
  function automatic longint blend_avg(longint avg, longint pid);
    longint acc;
    acc = avg * (longint'(ONE_Q16) - avg_alpha) + clip(pid, AVG_LO, AVG_HI) * avg_alpha
        + longint'(HALF_Q16);
    return clip(acc >>> Q16_SHIFT, AVG_LO, AVG_HI);
  endfunction

  // Truncate toward zero to whole units, then clamp
  function automatic longint wheel_cmd(longint q12);
    return clip(q12 / (64'sd1 <<< Q12_SHIFT), -longint'(DRIVE_LIMIT), longint'(DRIVE_LIMIT));
  endfunction

  // Advance both loops by one tracking sample and form the wheel word
  function automatic logic [15:0] pid_drive_step(logic [10:0] off, logic [9:0] rad);
    longint a_err, d_err, a_pid, d_pid, lw, rw;
    a_err = longint'($signed(off));
    d_err = tgt_dist - longint'(rad);
    a_err_sum = clip(a_err_sum + a_err, SUM_LO, SUM_HI);
    d_err_sum = clip(d_err_sum + d_err, SUM_LO, SUM_HI);
    a_pid = a_kp * a_err + a_kd * (a_err - prev_a_err) + a_ki * a_err_sum;
    d_pid = d_kp * d_err + d_kd * (d_err - prev_d_err) + d_ki * d_err_sum;
    a_avg = blend_avg(a_avg, a_pid);
    d_avg = blend_avg(d_avg, d_pid);
    prev_a_err = a_err;
    prev_d_err = d_err;
    lw = wheel_cmd(d_avg + a_avg);
    rw = wheel_cmd(d_avg - a_avg);
    return {rw[7:0], lw[7:0]};
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_TARGET_DISTANCE: tgt_dist  = longint'(val[9:0]);
      REG_ANGLE_P_GAIN:    a_kp      = longint'($signed(val[15:0]));
      REG_ANGLE_D_GAIN:    a_kd      = longint'($signed(val[15:0]));
      REG_ANGLE_I_GAIN:    a_ki      = longint'($signed(val[15:0]));
      REG_DIST_P_GAIN:     d_kp      = longint'($signed(val[15:0]));
      REG_DIST_D_GAIN:     d_kd      = longint'($signed(val[15:0]));
      REG_DIST_I_GAIN:     d_ki      = longint'($signed(val[15:0]));
      REG_SMOOTHING:       avg_alpha = longint'(val[15:0]);
      default: ;
    endcase
  endfunction

  // APB write: setup, access, then release
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_config(input logic [9:0] tgt, input logic [15:0] akp, akd, aki,
                             input logic [15:0] dkp, dkd, dki, alpha);
    write_reg(REG_TARGET_DISTANCE, {22'd0, tgt});
    write_reg(REG_ANGLE_P_GAIN, {16'd0, akp});
    write_reg(REG_ANGLE_D_GAIN, {16'd0, akd});
    write_reg(REG_ANGLE_I_GAIN, {16'd0, aki});
    write_reg(REG_DIST_P_GAIN, {16'd0, dkp});
    write_reg(REG_DIST_D_GAIN, {16'd0, dkd});
    write_reg(REG_DIST_I_GAIN, {16'd0, dki});
    write_reg(REG_SMOOTHING, {16'd0, alpha});
  endtask

  // Offer one word; called and returning at a falling edge, tvalid left high
  task automatic send_word(input logic kind, input logic [10:0] off, input logic [9:0] rad,
                           input logic typed = 1'b0, input logic [15:0] typed_word = 16'h0);
    int          gap;
    logic [15:0] pred;
    // Idle each cycle with the sender's idle odds
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {3'b000, rad, off};
    do @(posedge clk); while (!s_tready);
    if (kind == KIND_CLEAR) begin
      a_err_sum = 0;
      d_err_sum = 0;
    end else begin
      pred = pid_drive_step(off, rad);
      drive_cmd_q.push_back(typed ? typed_word : pred);
    end
    @(negedge clk);
  endtask

  // Drop tvalid and let the block drain before touching registers
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (drive_cmd_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Runs of random, held, jittered and extreme samples with sparse clears
  task automatic feed_random(input int n);
    int          sent;
    int          run_len;
    int          style;
    logic [10:0] base_off;
    logic [10:0] off;
    logic [9:0]  base_rad;
    logic [9:0]  rad;
    sent = 0;
    while (sent < n) begin
      run_len  = $urandom_range(1, 40);
      style    = $urandom_range(3);
      base_off = $urandom_range(1) ? 11'($urandom) : ($urandom_range(1) ? 11'h3FF : 11'h400);
      base_rad = $urandom_range(1) ? 10'($urandom) : ($urandom_range(1) ? 10'h3FF : 10'h000);
      for (int i = 0; i < run_len && sent < n; i++) begin
        if ($urandom_range(99) < 5) begin
          send_word(KIND_CLEAR, 11'($urandom), 10'($urandom));
        end else begin
          case (style)
            0: begin
              off = 11'($urandom);
              rad = 10'($urandom);
            end
            1: begin
              off = base_off + 11'($urandom_range(6)) - 11'd3;
              rad = base_rad + 10'($urandom_range(6)) - 10'd3;
            end
            2: begin
              off = $urandom_range(1) ? 11'h3FF : 11'h400;
              rad = $urandom_range(1) ? 10'h3FF : 10'h000;
            end
            default: begin
              off = base_off;
              rad = base_rad;
            end
          endcase
          send_word(KIND_SAMPLE, off, rad);
        end
        sent++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver backpressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check each delivered word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (drive_cmd_q.size() == 0) begin
        $error("unexpected word: left_drive %0d right_drive %0d",
               $signed(m_tdata[7:0]), $signed(m_tdata[15:8]));
        err_cnt++;
      end else begin
        want_word = drive_cmd_q.pop_front();
        if (m_tdata[7:0] !== want_word[7:0]) begin
          $error("left_drive: expected %0d, actual %0d",
                 $signed(want_word[7:0]), $signed(m_tdata[7:0]));
          err_cnt++;
        end
        if (m_tdata[15:8] !== want_word[15:8]) begin
          $error("right_drive: expected %0d, actual %0d",
                 $signed(want_word[15:8]), $signed(m_tdata[15:8]));
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = KIND_SAMPLE;
    m_tready      = 1'b0;
    err_cnt       = 0;
    cycle_cnt     = 0;
    send_idle_pct = 24;
    recv_idle_pct = 71;
    prev_a_err    = 0;
    prev_d_err    = 0;
    a_err_sum     = 0;
    d_err_sum     = 0;
    a_avg         = 0;
    d_avg         = 0;
    apply_reg(REG_TARGET_DISTANCE, {22'd0, TARGET_DISTANCE_RST});
    apply_reg(REG_ANGLE_P_GAIN, {16'd0, ANGLE_P_GAIN_RST});
    apply_reg(REG_ANGLE_D_GAIN, {16'd0, ANGLE_D_GAIN_RST});
    apply_reg(REG_ANGLE_I_GAIN, {16'd0, ANGLE_I_GAIN_RST});
    apply_reg(REG_DIST_P_GAIN, {16'd0, DIST_P_GAIN_RST});
    apply_reg(REG_DIST_D_GAIN, {16'd0, DIST_D_GAIN_RST});
    apply_reg(REG_DIST_I_GAIN, {16'd0, DIST_I_GAIN_RST});
    apply_reg(REG_SMOOTHING, {16'd0, SMOOTHING_RST});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words on reset settings, then random traffic
    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].kind, dir_tab[i].off, dir_tab[i].rad,
                dir_tab[i].typed, dir_tab[i].word);
    end
    feed_random(205);
    wait_drained();

    // All positive extremes, fastest averaging
    load_config(10'h3FF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    feed_random(205);
    wait_drained();

    // Negative extremes with frozen averages
    send_idle_pct = 71;
    recv_idle_pct = 24;
    load_config(10'h000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
    feed_random(205);
    wait_drained();

    load_config(10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    feed_random(205);
    wait_drained();

    // Slowest nonzero averaging
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_config(10'd180, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 16'h0001);
    feed_random(205);
    wait_drained();

    load_config(10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(65535, 32768)));
    feed_random(205);
    wait_drained();

    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
